### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the stereo mixer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define TSAM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TSAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define TSAM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tsam_pkg.sv
// ---------------------------------------------------------------------------
// tsam_pkg
// Types, widths and codes shared by the timestamp aligned stereo mixer.
// ---------------------------------------------------------------------------
package tsam_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SAMPLE_W    = 16;
    localparam int STAMP_W     = 63;
    localparam int ENTRY_W     = SAMPLE_W + STAMP_W;
    localparam int MIX_SHIFT   = 15;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [1:0] KIND_PUSH_LOCAL  = 2'd0;
    localparam logic [1:0] KIND_PUSH_REMOTE = 2'd1;
    localparam logic [1:0] KIND_EMIT        = 2'd2;

    localparam logic [1:0] STATUS_FRAME   = 2'd0;
    localparam logic [1:0] STATUS_PUSHED  = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;
    localparam logic [1:0] STATUS_STOPPED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_DECIDE,
        S_MUL,
        S_MIX,
        S_DONE
    } tsam_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } tsam_qctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } tsam_qstat_t;

endpackage

### rtl/core/tsam_queue.sv
// ---------------------------------------------------------------------------
// tsam_queue
// Circular queue of {sample, stamp} words in a synchronous memory with a
// registered head read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tsam_queue
    import tsam_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  tsam_qctrl_t                ctrl,
    input  logic signed [SAMPLE_W-1:0] push_sample,
    input  logic [STAMP_W-1:0]         push_stamp,
    output logic signed [SAMPLE_W-1:0] head_sample,
    output logic [STAMP_W-1:0]         head_stamp,
    output tsam_qstat_t                stat
);

    logic [ENTRY_W-1:0] entry_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W:0]   tail_sum;
    logic [PTR_W:0]   tail_wrap;
    logic [PTR_W-1:0] tail;

    assign tail_sum  = {1'b0, head_reg} + (PTR_W+1)'(count_reg);
    assign tail_wrap = (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH))
                     ? tail_sum - (PTR_W+1)'(QUEUE_DEPTH) : tail_sum;
    assign tail      = tail_wrap[PTR_W-1:0];

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            entry_mem[tail] <= {push_sample, push_stamp};
        end
        rd_data_reg <= entry_mem[head_reg];
    end

    assign head_sample = rd_data_reg[ENTRY_W-1:STAMP_W];
    assign head_stamp  = rd_data_reg[STAMP_W-1:0];

    `TSAM_ASSERT(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `TSAM_ASSERT_IMP(a_no_push_full, ctrl.push, !stat.full, "push into full queue")
    `TSAM_ASSERT_IMP(a_no_pop_empty, ctrl.pop, !stat.empty, "pop from empty queue")
    `TSAM_ASSERT_IMP(a_no_push_pop, ctrl.push, !ctrl.pop, "push and pop in one cycle")

endmodule

### rtl/core/timestamp_aligned_stereo_mixer_top.sv
// ---------------------------------------------------------------------------
// timestamp_aligned_stereo_mixer_top
// Two timestamped sample queues; emit words pop the earlier head(s) and
// produce a stereo frame plus an optional saturated mono mix, or stop.
// ---------------------------------------------------------------------------
// Path: a push goes through S_PUSH and S_DONE to the output register, a
//   stopped emit through S_DECIDE and S_DONE, an emitted frame through
//   head compare, multiply, mix, S_DONE and the output register.
// Throughput: one word at a time, set by the sequencer around the registered
//   queue memory read and the mix multiplier stage, and by result_stall.
// Reset: queue pointers, counts, merge_mode and handshakes clear at once.
module timestamp_aligned_stereo_mixer_top
    import tsam_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       merge_mode,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [1:0]                 kind,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [STAMP_W-1:0]         stamp,
    input  logic [STAMP_W-1:0]         window_low,
    input  logic [STAMP_W-1:0]         window_high,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [1:0]                 status,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out,
    output logic signed [SAMPLE_W-1:0] mono_out,
    output logic [STAMP_W-1:0]         frame_stamp
);

    tsam_state_t state_reg;
    tsam_state_t state_next;

    logic merge_reg;

    logic [1:0]                 kind_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [STAMP_W-1:0]         stamp_reg;
    logic [STAMP_W-1:0]         low_reg;
    logic [STAMP_W-1:0]         high_reg;

    tsam_qctrl_t                l_ctrl;
    tsam_qctrl_t                r_ctrl;
    tsam_qstat_t                l_stat;
    tsam_qstat_t                r_stat;
    logic signed [SAMPLE_W-1:0] l_sample;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [STAMP_W-1:0]         l_stamp;
    logic [STAMP_W-1:0]         r_stamp;

    logic                       remote_only;
    logic                       local_only;
    logic                       take_l;
    logic                       take_r;
    logic [STAMP_W-1:0]         chosen;
    logic                       stop;
    logic signed [SAMPLE_W-1:0] left_sel;
    logic signed [SAMPLE_W-1:0] right_sel;

    logic signed [SAMPLE_W-1:0] res_left_reg;
    logic signed [SAMPLE_W-1:0] res_right_reg;
    logic signed [SAMPLE_W-1:0] res_mono_reg;
    logic [1:0]                 res_status_reg;
    logic [STAMP_W-1:0]         res_stamp_reg;
    logic signed [31:0]         prod_reg;

    logic signed [31:0]         prod_adj;
    logic signed [16:0]         quot;
    logic signed [18:0]         mix_sum;
    logic signed [SAMPLE_W-1:0] mix_sat;

    logic                       out_valid_reg;
    logic                       out_load;
    logic [1:0]                 out_status_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg;
    logic signed [SAMPLE_W-1:0] out_right_reg;
    logic signed [SAMPLE_W-1:0] out_mono_reg;
    logic [STAMP_W-1:0]         out_stamp_reg;

    tsam_queue u_local_q (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (l_ctrl),
        .push_sample (sample_reg),
        .push_stamp  (stamp_reg),
        .head_sample (l_sample),
        .head_stamp  (l_stamp),
        .stat        (l_stat)
    );

    tsam_queue u_remote_q (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (r_ctrl),
        .push_sample (sample_reg),
        .push_stamp  (stamp_reg),
        .head_sample (r_sample),
        .head_stamp  (r_stamp),
        .stat        (r_stat)
    );

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            merge_reg <= merge_mode;
        end
    end

    // head selection
    always_comb
    begin
        remote_only = l_stat.empty || (!r_stat.empty && (r_stamp < l_stamp));
        local_only  = !remote_only && (r_stat.empty || (l_stamp < r_stamp));
        take_l      = !remote_only;
        take_r      = !local_only;
        chosen      = remote_only ? r_stamp : l_stamp;
        stop        = (low_reg > high_reg) || (l_stat.empty && r_stat.empty)
                   || (chosen < low_reg) || (chosen > high_reg);
        left_sel    = take_l ? l_sample : '0;
        right_sel   = take_r ? r_sample : '0;
        if (merge_reg)
        begin
            if (!take_l)
            begin
                left_sel = r_sample;
            end
            if (!take_r)
            begin
                right_sel = l_sample;
            end
        end
    end

    // mono mix: a + b -/+ trunc(a*b / 32768), saturated
    always_comb
    begin
        prod_adj = prod_reg + ((prod_reg < 0) ? 32'sd32767 : 32'sd0);
        quot     = prod_adj[31:MIX_SHIFT];
        if (res_left_reg[SAMPLE_W-1] && res_right_reg[SAMPLE_W-1])
        begin
            mix_sum = 19'(res_left_reg) + 19'(res_right_reg) + 19'(quot);
        end
        else
        begin
            mix_sum = 19'(res_left_reg) + 19'(res_right_reg) - 19'(quot);
        end
        if (mix_sum > 19'(SAMPLE_MAX))
        begin
            mix_sat = SAMPLE_MAX;
        end
        else if (mix_sum < 19'(SAMPLE_MIN))
        begin
            mix_sat = SAMPLE_MIN;
        end
        else
        begin
            mix_sat = mix_sum[SAMPLE_W-1:0];
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        l_ctrl     = '0;
        r_ctrl     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (kind)
                        KIND_PUSH_LOCAL, KIND_PUSH_REMOTE: state_next = S_PUSH;
                        KIND_EMIT:                         state_next = S_DECIDE;
                        default:                           state_next = S_IDLE;
                    endcase
                end
            end
            S_PUSH:
            begin
                if (kind_reg == KIND_PUSH_LOCAL)
                begin
                    l_ctrl.push = !l_stat.full;
                end
                else
                begin
                    r_ctrl.push = !r_stat.full;
                end
                state_next = S_DONE;
            end
            S_DECIDE:
            begin
                if (stop)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    l_ctrl.pop = take_l;
                    r_ctrl.pop = take_r;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_MIX;
            end
            S_MIX:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                kind_reg   <= kind;
                sample_reg <= sample;
                stamp_reg  <= stamp;
                low_reg    <= window_low;
                high_reg   <= window_high;
            end
            S_PUSH:
            begin
                res_left_reg  <= '0;
                res_right_reg <= '0;
                res_mono_reg  <= '0;
                res_stamp_reg <= '0;
                if (kind_reg == KIND_PUSH_LOCAL)
                begin
                    res_status_reg <= l_stat.full ? STATUS_DROPPED : STATUS_PUSHED;
                end
                else
                begin
                    res_status_reg <= r_stat.full ? STATUS_DROPPED : STATUS_PUSHED;
                end
            end
            S_DECIDE:
            begin
                res_mono_reg <= '0;
                if (stop)
                begin
                    res_status_reg <= STATUS_STOPPED;
                    res_left_reg   <= '0;
                    res_right_reg  <= '0;
                    res_stamp_reg  <= '0;
                end
                else
                begin
                    res_status_reg <= STATUS_FRAME;
                    res_left_reg   <= left_sel;
                    res_right_reg  <= right_sel;
                    res_stamp_reg  <= chosen;
                end
            end
            S_MUL:
            begin
                prod_reg <= res_left_reg * res_right_reg;
            end
            S_MIX:
            begin
                res_mono_reg <= merge_reg ? mix_sat : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_left_reg   <= res_left_reg;
            out_right_reg  <= res_right_reg;
            out_mono_reg   <= res_mono_reg;
            out_stamp_reg  <= res_stamp_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign left_out     = out_left_reg;
    assign right_out    = out_right_reg;
    assign mono_out     = out_mono_reg;
    assign frame_stamp  = out_stamp_reg;

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the timestamp aligned stereo mixer. Push and emit
// words go in with random bursts and gaps while the result side stalls on its
// own pattern. A scoreboard mirrors both sample queues and the merge setting
// and predicts each result word. Every result is compared field by field.
// ----------------------------------------------------------------------------
import tsam_pkg::*;

localparam logic [1:0]         KIND_UNUSED    = 2'd3;
localparam logic [STAMP_W-1:0] STAMP_TOP      = '1;
localparam int                 SETTLE_CYCLES  = 12;
localparam int                 HOLD_CYCLES    = 400;
localparam int                 WATCHDOG_LIMIT = 4000;

typedef struct packed {
    logic [1:0]                 kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [STAMP_W-1:0]         stamp;
    logic [STAMP_W-1:0]         lo;
    logic [STAMP_W-1:0]         hi;
} mixer_word_t;

typedef struct packed {
    logic [1:0]                 status;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] mono;
    logic [STAMP_W-1:0]         stamp;
} mixer_frame_t;

typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic [STAMP_W-1:0]         stp;
} queue_entry_t;

function automatic int saturating_mix(input int a, input int b);
    int sum;
    int q;
    sum = a + b;
    q   = (a * b) / 32768;
    if (a < 0 && b < 0)
        sum = sum + q;
    else
        sum = sum - q;
    if (sum > int'(SAMPLE_MAX))
        sum = int'(SAMPLE_MAX);
    else if (sum < int'(SAMPLE_MIN))
        sum = int'(SAMPLE_MIN);
    return sum;
endfunction

class mixer_scoreboard;
    bit           merge;
    int           errors;
    int           frames;
    int           mixed;
    int           stops;
    int           drops;
    queue_entry_t local_fifo[$];
    queue_entry_t remote_fifo[$];
    mixer_frame_t expected_frames[$];

    function int pending();
        return expected_frames.size();
    endfunction

    function logic [STAMP_W-1:0] earliest_head();
        if (local_fifo.size() > 0 && remote_fifo.size() > 0)
            return (local_fifo[0].stp < remote_fifo[0].stp) ? local_fifo[0].stp
                                                            : remote_fifo[0].stp;
        if (local_fifo.size() > 0)
            return local_fifo[0].stp;
        if (remote_fifo.size() > 0)
            return remote_fifo[0].stp;
        return '0;
    endfunction

    function void note_word(input mixer_word_t w);
        mixer_frame_t       f;
        queue_entry_t       e;
        bit                 lv;
        bit                 rv;
        bit                 take_l;
        bit                 take_r;
        logic [STAMP_W-1:0] ls;
        logic [STAMP_W-1:0] rs;
        logic [STAMP_W-1:0] chosen;
        int                 left;
        int                 right;
        f = '0;
        e.smp = w.sample;
        e.stp = w.stamp;
        case (w.kind)
            KIND_PUSH_LOCAL:
            begin
                if (local_fifo.size() >= QUEUE_DEPTH)
                begin
                    f.status = STATUS_DROPPED;
                    drops++;
                end
                else
                begin
                    local_fifo = {local_fifo, e};
                    f.status = STATUS_PUSHED;
                end
            end
            KIND_PUSH_REMOTE:
            begin
                if (remote_fifo.size() >= QUEUE_DEPTH)
                begin
                    f.status = STATUS_DROPPED;
                    drops++;
                end
                else
                begin
                    remote_fifo = {remote_fifo, e};
                    f.status = STATUS_PUSHED;
                end
            end
            KIND_EMIT:
            begin
                lv = local_fifo.size() > 0;
                rv = remote_fifo.size() > 0;
                ls = lv ? local_fifo[0].stp : '0;
                rs = rv ? remote_fifo[0].stp : '0;
                if (!lv || (rv && rs < ls))
                begin
                    take_l = 0; take_r = 1; chosen = rs;
                end
                else if (!rv || ls < rs)
                begin
                    take_l = 1; take_r = 0; chosen = ls;
                end
                else
                begin
                    take_l = 1; take_r = 1; chosen = ls;
                end
                if (w.lo > w.hi || (!lv && !rv) || chosen < w.lo || chosen > w.hi)
                begin
                    f.status = STATUS_STOPPED;
                    stops++;
                end
                else
                begin
                    left  = 0;
                    right = 0;
                    if (take_l)
                    begin
                        e    = local_fifo.pop_front();
                        left = int'(e.smp);
                    end
                    if (take_r)
                    begin
                        e     = remote_fifo.pop_front();
                        right = int'(e.smp);
                    end
                    if (merge)
                    begin
                        if (!take_l) left = right;
                        if (!take_r) right = left;
                        f.mono = SAMPLE_W'(saturating_mix(left, right));
                        mixed++;
                    end
                    f.status = STATUS_FRAME;
                    f.left   = SAMPLE_W'(left);
                    f.right  = SAMPLE_W'(right);
                    f.stamp  = chosen;
                    frames++;
                end
            end
            default: return;
        endcase
        expected_frames = {expected_frames, f};
    endfunction

    function void check_frame(input mixer_frame_t got);
        mixer_frame_t want;
        if (expected_frames.size() == 0)
        begin
            $error("result word with none pending: status %0d", got.status);
            errors++;
            return;
        end
        want = expected_frames.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.left !== want.left)
        begin
            $error("left_out: expected %0d, got %0d", want.left, got.left);
            errors++;
        end
        if (got.right !== want.right)
        begin
            $error("right_out: expected %0d, got %0d", want.right, got.right);
            errors++;
        end
        if (got.mono !== want.mono)
        begin
            $error("mono_out: expected %0d, got %0d", want.mono, got.mono);
            errors++;
        end
        if (got.stamp !== want.stamp)
        begin
            $error("frame_stamp: expected %0h, got %0h", want.stamp, got.stamp);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic                       cfg_mode;
    logic                       item_valid;
    logic                       item_stall;
    logic [1:0]                 kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [STAMP_W-1:0]         stamp;
    logic [STAMP_W-1:0]         window_low;
    logic [STAMP_W-1:0]         window_high;
    logic                       result_valid;
    logic                       result_stall;
    logic [1:0]                 status;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic signed [SAMPLE_W-1:0] mono_out;
    logic [STAMP_W-1:0]         frame_stamp;

    mixer_scoreboard    sb = new();
    bit                 hold_request;
    int                 burst_left;
    int                 steady_words;
    int                 words_sent;
    int                 cfg_writes;
    int                 quiet_cycles;
    logic [STAMP_W-1:0] loc_next;
    logic [STAMP_W-1:0] rem_next;

    timestamp_aligned_stereo_mixer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .merge_mode   (cfg_mode),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .sample       (sample),
        .stamp        (stamp),
        .window_low   (window_low),
        .window_high  (window_high),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .left_out     (left_out),
        .right_out    (right_out),
        .mono_out     (mono_out),
        .frame_stamp  (frame_stamp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stall segments, plus one long hold-off on request
    initial
    begin
        int pct;
        int seg;
        result_stall = 1'b0;
        hold_request = 1'b0;
        forever
        begin
            case ($urandom_range(4))
                0, 1:    pct = 0;
                2:       pct = 30;
                3:       pct = 60;
                default: pct = 90;
            endcase
            seg = $urandom_range(20, 200);
            repeat (seg)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    result_stall <= 1'b1;
                    repeat (HOLD_CYCLES - 1) @(negedge clk);
                end
                else
                    result_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    always @(posedge clk)
    begin
        mixer_frame_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.status = status;
            got.left   = left_out;
            got.right  = right_out;
            got.mono   = mono_out;
            got.stamp  = frame_stamp;
            sb.check_frame(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [STAMP_W-1:0] rand63();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[STAMP_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic mixer_word_t make_word(input logic [1:0] k,
                                              input logic signed [SAMPLE_W-1:0] s,
                                              input logic [STAMP_W-1:0] t,
                                              input logic [STAMP_W-1:0] lo,
                                              input logic [STAMP_W-1:0] hi);
        mixer_word_t w;
        w.kind   = k;
        w.sample = s;
        w.stamp  = t;
        w.lo     = lo;
        w.hi     = hi;
        return w;
    endfunction

    // in-order push with a slowly rising stamp so heads tie now and then
    function automatic mixer_word_t next_push(input logic [1:0] k);
        mixer_word_t w;
        if (k == KIND_PUSH_LOCAL)
        begin
            w = make_word(k, pick_sample(), loc_next, rand63(), rand63());
            loc_next = loc_next + STAMP_W'($urandom_range(0, 3));
        end
        else
        begin
            w = make_word(k, pick_sample(), rem_next, rand63(), rand63());
            rem_next = rem_next + STAMP_W'($urandom_range(0, 3));
        end
        return w;
    endfunction

    task automatic offer(input mixer_word_t w);
        int gap;
        if (steady_words > 0)
            steady_words--;
        else if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
            end
        end
        else
            burst_left--;
        @(negedge clk);
        item_valid  <= 1'b1;
        kind        <= w.kind;
        sample      <= w.sample;
        stamp       <= w.stamp;
        window_low  <= w.lo;
        window_high <= w.hi;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_merge(input bit m);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_mode  <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.merge = m;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_flow(input int count, input bit squeeze);
        int                 done;
        int                 r;
        mixer_word_t        w;
        logic [STAMP_W-1:0] h;
        logic [STAMP_W-1:0] lo;
        logic [STAMP_W-1:0] hi;
        loc_next = rand63() >> 1;
        rem_next = $urandom_range(1) ? loc_next
                                     : loc_next + STAMP_W'($urandom_range(0, 5));
        done = 0;
        while (done < count)
        begin
            if (squeeze && done == 40)
            begin
                hold_request = 1'b1;
                steady_words = 80;
            end
            r = $urandom_range(99);
            if (r < 4)
                w = make_word(2'($urandom_range(3)), pick_sample(), rand63(), rand63(),
                              rand63());
            else if (r < 35)
                w = next_push(KIND_PUSH_LOCAL);
            else if (r < 66)
                w = next_push(KIND_PUSH_REMOTE);
            else
            begin
                h = sb.earliest_head();
                case ($urandom_range(9))
                    5, 6:
                    begin
                        lo = h - STAMP_W'(1) + STAMP_W'($urandom_range(0, 2));
                        hi = h - STAMP_W'(1) + STAMP_W'($urandom_range(0, 2));
                    end
                    7:
                    begin
                        lo = rand63();
                        hi = lo - STAMP_W'(1) - STAMP_W'($urandom_range(0, 3));
                    end
                    8:
                    begin
                        lo = rand63();
                        hi = rand63();
                    end
                    9:
                    begin
                        lo = $urandom_range(1) ? h : '0;
                        hi = (lo == h) ? STAMP_TOP : h;
                    end
                    default:
                    begin
                        lo = '0;
                        hi = STAMP_TOP;
                    end
                endcase
                w = make_word(KIND_EMIT, pick_sample(), rand63(), lo, hi);
            end
            offer(w);
            if (w.kind != KIND_UNUSED)
                done++;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_mode     = 1'b0;
        item_valid   = 1'b0;
        kind         = KIND_PUSH_LOCAL;
        sample       = '0;
        stamp        = '0;
        window_low   = '0;
        window_high  = '0;
        burst_left   = 0;
        steady_words = 0;
        words_sent   = 0;
        cfg_writes   = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // separate channels
        offer(make_word(KIND_EMIT, '0, '0, '0, STAMP_TOP));
        offer(make_word(KIND_PUSH_LOCAL, SAMPLE_MAX, 63'd10, '0, '0));
        offer(make_word(KIND_PUSH_REMOTE, SAMPLE_MIN, 63'd10, '0, '0));
        offer(make_word(KIND_EMIT, '0, '0, 63'd5, 63'd4));
        offer(make_word(KIND_EMIT, '0, '0, 63'd11, STAMP_TOP));
        offer(make_word(KIND_EMIT, '0, '0, 63'd10, 63'd10));
        offer(make_word(KIND_PUSH_LOCAL, SAMPLE_MIN, STAMP_TOP, '0, '0));
        offer(make_word(KIND_PUSH_REMOTE, SAMPLE_MAX, '0, '0, '0));
        offer(make_word(KIND_EMIT, '0, '0, '0, STAMP_TOP));
        offer(make_word(KIND_EMIT, '0, '0, '0, STAMP_TOP - 1));
        offer(make_word(KIND_EMIT, '0, '0, STAMP_TOP, STAMP_TOP));
        offer(make_word(KIND_UNUSED, '1, STAMP_TOP, STAMP_TOP, STAMP_TOP));
        offer(make_word(KIND_PUSH_REMOTE, -16'sd1, 63'd20, '0, '0));
        offer(make_word(KIND_EMIT, '0, '0, '0, 63'd19));
        offer(make_word(KIND_EMIT, '0, '0, 63'd20, STAMP_TOP));

        // mono mix
        write_merge(1'b1);
        offer(make_word(KIND_PUSH_LOCAL, SAMPLE_MIN, 63'd1, '0, '0));
        offer(make_word(KIND_PUSH_REMOTE, SAMPLE_MIN, 63'd1, '0, '0));
        offer(make_word(KIND_EMIT, '0, '0, '0, STAMP_TOP));
        offer(make_word(KIND_PUSH_LOCAL, SAMPLE_MAX, 63'd2, '0, '0));
        offer(make_word(KIND_EMIT, '0, '0, '0, STAMP_TOP));
        offer(make_word(KIND_PUSH_REMOTE, SAMPLE_MIN, 63'd3, '0, '0));
        offer(make_word(KIND_EMIT, '0, '0, '0, STAMP_TOP));
        offer(make_word(KIND_PUSH_LOCAL, 16'sd1000, 63'd4, '0, '0));
        offer(make_word(KIND_PUSH_REMOTE, -16'sd2000, 63'd4, '0, '0));
        offer(make_word(KIND_EMIT, '0, '0, '0, STAMP_TOP));
        offer(make_word(KIND_EMIT, '0, '0, '0, STAMP_TOP));

        write_merge(1'b0);
        run_flow(150, 1'b0);
        write_merge(1'b1);
        run_flow(150, 1'b1);
        write_merge(1'b0);
        run_flow(150, 1'b0);
        write_merge(1'b1);
        run_flow(150, 1'b0);
        settle();

        $display("Run covered %0d words: %0d frames (%0d mixed to mono), %0d stopped emits,",
                 words_sent, sb.frames, sb.mixed, sb.stops);
        $display("%0d drops on a full queue, %0d merge_mode writes, one long result hold-off",
                 sb.drops, cfg_writes);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
